/* design/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted (active-low reset)
`define STC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that is also checked during reset
`define STC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/stc_pkg.sv */
`default_nettype none

package stc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_PERIOD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHADOW_DURATION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRAVEL_STEPS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME   = 3'd4;

  // register values after reset
  localparam logic [31:0] RST_FORWARD_PERIOD  = 32'd243304;
  localparam logic [31:0] RST_RETURN_PERIOD   = 32'd10000;
  localparam logic [31:0] RST_SHADOW_DURATION = 32'd2580000000;
  localparam logic [15:0] RST_TRAVEL_STEPS    = 16'd13440;
  localparam logic [31:0] RST_DEBOUNCE_TIME   = 32'd200000;

  // phase codes as seen on the result channel
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_SUN    = 2'd1;
  localparam logic [1:0] PHASE_SHADOW = 2'd2;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_RETURN  = 1'b1;

  typedef struct packed {
    logic [31:0] forward_period;
    logic [31:0] return_period;
    logic [31:0] shadow_duration;
    logic [15:0] travel_steps;
    logic [31:0] debounce_time;
  } cfg_t;

  typedef struct packed {
    logic       step_pulse;
    logic       step_dir;
    logic [1:0] phase_now;
    logic [7:0] cycle_count;
    logic       cycle_done;
  } res_t;

endpackage

`default_nettype wire

/* design/stc_cfg_regs.sv */
`default_nettype none

module stc_cfg_regs
  import stc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_FORWARD_PERIOD:  cfg_nxt.forward_period  = wr_data;
        CFG_RETURN_PERIOD:   cfg_nxt.return_period   = wr_data;
        CFG_SHADOW_DURATION: cfg_nxt.shadow_duration = wr_data;
        CFG_TRAVEL_STEPS:    cfg_nxt.travel_steps    = wr_data[15:0];
        CFG_DEBOUNCE_TIME:   cfg_nxt.debounce_time   = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.forward_period  <= RST_FORWARD_PERIOD;
      cfg_r.return_period   <= RST_RETURN_PERIOD;
      cfg_r.shadow_duration <= RST_SHADOW_DURATION;
      cfg_r.travel_steps    <= RST_TRAVEL_STEPS;
      cfg_r.debounce_time   <= RST_DEBOUNCE_TIME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* design/stc_seq.sv */
`default_nettype none

module stc_seq
  import stc_pkg::*;
#(
  parameter int TIMER_WIDTH    = 32,
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      start_level,
  input  wire cfg_t                      cfg,
  output res_t                           res_nxt,
  output logic [POSITION_WIDTH-1:0]      position_nxt
);

  // compare widths wide enough for both the timer and the register
  localparam int CW  = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
  localparam int PCW = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;

  localparam logic [TIMER_WIDTH-1:0]    TMAX = {TIMER_WIDTH{1'b1}};
  localparam logic [TIMER_WIDTH-1:0]    TONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [POSITION_WIDTH-1:0] PONE = {{(POSITION_WIDTH-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    PH_IDLE   = PHASE_IDLE,
    PH_SUN    = PHASE_SUN,
    PH_SHADOW = PHASE_SHADOW
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [TIMER_WIDTH-1:0]    step_tmr_r, step_tmr_nxt;
  logic [TIMER_WIDTH-1:0]    shadow_tmr_r, shadow_tmr_nxt;
  logic [TIMER_WIDTH-1:0]    deb_tmr_r, deb_tmr_nxt;
  logic                      pin_last_r;
  logic [7:0]                cycles_r, cycles_nxt;
  logic                      pulse, dir, done;

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    cycles_nxt     = cycles_r;
    pulse          = 1'b0;
    dir            = DIR_FORWARD;
    done           = 1'b0;
    // all timers advance first, saturating
    step_tmr_nxt   = (step_tmr_r == TMAX) ? step_tmr_r : step_tmr_r + TONE;
    shadow_tmr_nxt = (shadow_tmr_r == TMAX) ? shadow_tmr_r : shadow_tmr_r + TONE;
    deb_tmr_nxt    = (deb_tmr_r == TMAX) ? deb_tmr_r : deb_tmr_r + TONE;

    // debounced rising edge on the start pin
    if (start_level && !pin_last_r &&
        (CW'(deb_tmr_nxt) >= CW'(cfg.debounce_time))) begin
      deb_tmr_nxt = '0;
      if (phase_r == PH_IDLE) begin
        phase_nxt    = PH_SUN;
        pos_nxt      = '0;
        step_tmr_nxt = TMAX;
        cycles_nxt   = cycles_r + 8'd1;
      end
    end

    unique case (phase_nxt)
      PH_SUN: begin
        if ((PCW'(pos_nxt) < PCW'(cfg.travel_steps)) &&
            (CW'(step_tmr_nxt) >= CW'(cfg.forward_period))) begin
          step_tmr_nxt = '0;
          pos_nxt      = pos_nxt + PONE;
          pulse        = 1'b1;
        end
        // end of travel, return steps start on the next tick
        if (PCW'(pos_nxt) >= PCW'(cfg.travel_steps)) begin
          phase_nxt      = PH_SHADOW;
          shadow_tmr_nxt = '0;
          step_tmr_nxt   = TMAX;
        end
      end
      PH_SHADOW: begin
        if (CW'(shadow_tmr_nxt) >= CW'(cfg.shadow_duration)) begin
          phase_nxt = PH_IDLE;
          pos_nxt   = '0;
          done      = 1'b1;
        end else if ((pos_nxt != '0) &&
                     (CW'(step_tmr_nxt) >= CW'(cfg.return_period))) begin
          step_tmr_nxt = '0;
          pos_nxt      = pos_nxt - PONE;
          pulse        = 1'b1;
          dir          = DIR_RETURN;
        end
      end
      PH_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      step_tmr_r   <= TMAX;
      shadow_tmr_r <= '0;
      deb_tmr_r    <= '0;
      pin_last_r   <= 1'b1;
      cycles_r     <= '0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      step_tmr_r   <= step_tmr_nxt;
      shadow_tmr_r <= shadow_tmr_nxt;
      deb_tmr_r    <= deb_tmr_nxt;
      pin_last_r   <= start_level;
      cycles_r     <= cycles_nxt;
    end
  end

  always_comb begin
    res_nxt.step_pulse  = pulse;
    res_nxt.step_dir    = dir;
    res_nxt.phase_now   = phase_nxt;
    res_nxt.cycle_count = cycles_nxt;
    res_nxt.cycle_done  = done;
  end

  assign position_nxt = pos_nxt;

endmodule

`default_nettype wire

/* design/stepper_travel_cycle_sequencer_core.sv */
// stepper travel cycle sequencer
//
// input channel: one transaction per timer tick, carrying the sampled start
// pin level (in_valid / in_stall / in_start_level)
// result channel: exactly one transaction per input tick with step pulse,
// direction, position, phase, cycle count and cycle-done flag
// config channel: cfg_valid / cfg_ready with a register index and 32-bit data;
// cfg_ready is always high, writes take effect on the next tick processed
//
// an accepted tick waits in the input register, and its result then lands in the result register
// throughput: one tick per cycle while the receiver does not stall, set by the state update that
// runs between the input register and the result register
// a full result register with the receiver stalling holds its payload; the
// input register still takes one more tick, then in_stall rises
// reset: phase idle, position zero, step timer saturated, start pin taken as
// high, cycle count zero, registers back to their default values
`default_nettype none

module stepper_travel_cycle_sequencer_core
  import stc_pkg::*;
#(
  parameter int TIMER_WIDTH    = 32,
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_start_level,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_step_pulse,
  output logic                           out_step_dir,
  output logic [POSITION_WIDTH-1:0]      out_position,
  output logic [1:0]                     out_phase_now,
  output logic [7:0]                     out_cycle_count,
  output logic                           out_cycle_done,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t                      cfg;
  res_t                      res_nxt;
  logic [POSITION_WIDTH-1:0] pos_nxt;

  logic                      in_v_r;
  logic                      in_level_r;
  logic                      out_v_r;
  res_t                      res_r;
  logic [POSITION_WIDTH-1:0] pos_r;
  logic                      out_free;
  logic                      adv;
  logic                      in_take;

  assign cfg_ready = 1'b1;

  stc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  stc_seq #(
    .TIMER_WIDTH    (TIMER_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .start_level  (in_level_r),
    .cfg          (cfg),
    .res_nxt      (res_nxt),
    .position_nxt (pos_nxt)
  );

  // result register frees up when empty or when its transaction leaves
  assign out_free = !out_v_r || !out_stall;
  assign adv      = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_start_level;
    end
    if (adv) begin
      res_r <= res_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_step_pulse  = res_r.step_pulse;
  assign out_step_dir    = res_r.step_dir;
  assign out_position    = pos_r;
  assign out_phase_now   = res_r.phase_now;
  assign out_cycle_count = res_r.cycle_count;
  assign out_cycle_done  = res_r.cycle_done;

endmodule

`default_nettype wire

/* design/stc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module stc_checker
  import stc_pkg::*;
#(
  parameter int POSITION_WIDTH = 16
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      out_step_pulse,
  input wire logic                      out_step_dir,
  input wire logic [POSITION_WIDTH-1:0] out_position,
  input wire logic [1:0]                out_phase_now,
  input wire logic [7:0]                out_cycle_done_pad,
  input wire logic                      out_cycle_done
);

  // a finished cycle leaves the block idle at position zero
  `STC_ASSERT(a_done_idle, clk, rst_n, out_valid && out_cycle_done |-> out_phase_now == PHASE_IDLE && out_position == '0, "cycle_done without idle at zero")

  // the end of the shadow wait takes priority over a return step
  `STC_ASSERT(a_done_no_step, clk, rst_n, out_valid && out_cycle_done |-> !out_step_pulse, "step issued on cycle end")

  // return direction only accompanies an actual step taken in the shadow phase
  `STC_ASSERT(a_dir_step, clk, rst_n, out_valid && out_step_dir |-> out_step_pulse && out_phase_now == PHASE_SHADOW, "return direction without shadow step")

  // a stalled result transaction holds, checked on its position and cycle count
  `STC_ASSERT(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_position) && $stable(out_cycle_done_pad), "stalled result changed")

  // nothing leaves the block right after reset
  `STC_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind stepper_travel_cycle_sequencer_core stc_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_stc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_step_pulse     (out_step_pulse),
  .out_step_dir       (out_step_dir),
  .out_position       (out_position),
  .out_phase_now      (out_phase_now),
  .out_cycle_done_pad (out_cycle_count),
  .out_cycle_done     (out_cycle_done)
);

`default_nettype wire
